>>> hdl/cdi_pkg.sv
// Shared types, constants and helper functions of the coning delta-angle integrator.
package cdi_pkg;

    localparam int NUM_SENSORS_DEF = 4;

    localparam int GYRO_W   = 24;
    localparam int ANGLE_W  = 40;
    localparam int TIME_W   = 32;
    localparam int PERIOD_W = 16;
    localparam int GAP_W    = 20;

    localparam int IN_DATA_W  = 144;
    localparam int OUT_DATA_W = 152;
    localparam int OUT_USER_W = 2;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_NOMINAL_PERIOD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_TIMEOUT    = 1'd1;

    localparam logic KIND_SAMPLE  = 1'b0;
    localparam logic KIND_PUBLISH = 1'b1;

    localparam logic [PERIOD_W-1:0] MAX_PERIOD_US   = 16'd25000;
    localparam logic [GAP_W-1:0]    GAP_TIMEOUT_RST = 20'd100000;

    // shared multiplier: 40 x 20 unsigned, two passes per full product
    localparam int MUL_AW = 40;
    localparam int MUL_BW = 20;
    localparam int MUL_PW = MUL_AW + MUL_BW;
    localparam int FULL_W = MUL_AW + 2 * MUL_BW;

    // constant divider: radix-256 long division
    localparam int DIV_W      = 72;
    localparam int DIV_DIGIT  = 8;
    localparam int DIV_STEPS  = DIV_W / DIV_DIGIT;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
    localparam int DIV_RW     = 14;
    localparam logic [DIV_RW-1:0] TRAP_DIVISOR = 14'd15625;
    localparam logic [DIV_RW-1:0] CONE_DIVISOR = 14'd6;

    localparam int MAG_W = 56;
    localparam logic [MAG_W-1:0] MAG_POS_LIM = 56'h7F_FFFF_FFFF;
    localparam logic [MAG_W-1:0] MAG_NEG_LIM = 56'h80_0000_0000;
    localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = 40'sh7F_FFFF_FFFF;
    localparam logic signed [ANGLE_W-1:0] ANGLE_MIN = 40'sh80_0000_0000;

    typedef struct packed {
        logic [MUL_AW-1:0] a;
        logic [MUL_BW-1:0] b;
    } cdi_mul_req_t;

    typedef struct packed {
        logic             start;
        logic             cone;
        logic [DIV_W-1:0] dividend;
    } cdi_div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } cdi_div_rsp_t;

    function automatic logic [ANGLE_W-1:0] abs40(input logic signed [ANGLE_W-1:0] x);
        return x[ANGLE_W-1] ? ANGLE_W'(-x) : ANGLE_W'(x);
    endfunction

    // saturate a 49-bit signed sum to 40 bits
    function automatic logic signed [ANGLE_W-1:0] sat40(input logic signed [48:0] x);
        logic signed [ANGLE_W-1:0] r;
        if (x[48:ANGLE_W-1] != {10{x[48]}}) begin
            r = x[48] ? ANGLE_MIN : ANGLE_MAX;
        end else begin
            r = x[ANGLE_W-1:0];
        end
        return r;
    endfunction

    // put the sign back on a magnitude and saturate to 40 bits
    function automatic logic signed [ANGLE_W-1:0] sat_mag(input logic neg,
                                                          input logic [MAG_W-1:0] mag);
        logic signed [ANGLE_W-1:0] r;
        if (neg) begin
            r = (mag > MAG_NEG_LIM) ? ANGLE_MIN : ANGLE_W'(-mag[ANGLE_W-1:0]);
        end else begin
            r = (mag > MAG_POS_LIM) ? ANGLE_MAX : ANGLE_W'(mag[ANGLE_W-1:0]);
        end
        return r;
    endfunction

endpackage

>>> hdl/cdi_mul.sv
// Shared registered 40 x 20 unsigned multiplier.
module cdi_mul (
    input  logic                        aclk,
    input  cdi_pkg::cdi_mul_req_t       mul_req,
    output logic [cdi_pkg::MUL_PW-1:0]  mul_pp
);
    import cdi_pkg::*;

    logic [MUL_PW-1:0] pp_reg;

    always_ff @(posedge aclk) begin
        pp_reg <= MUL_PW'(mul_req.a) * MUL_PW'(mul_req.b);
    end

    assign mul_pp = pp_reg;

endmodule

>>> hdl/cdi_div.sv
// Shared long divider by a constant (15625 or 6), eight quotient bits per cycle.
module cdi_div (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cdi_pkg::cdi_div_req_t div_req,
    output cdi_pkg::cdi_div_rsp_t div_rsp
);
    import cdi_pkg::*;

    logic [DIV_W-1:0]     dvd_reg;
    logic [DIV_W-1:0]     quo_reg;
    logic [DIV_RW-1:0]    rem_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic                 cone_reg;

    logic [DIV_RW-1:0]    divisor;
    logic [DIV_RW-1:0]    rem_next;
    logic [DIV_RW:0]      trial;
    logic [DIV_DIGIT-1:0] qdigit;

    always_comb begin
        divisor  = cone_reg ? CONE_DIVISOR : TRAP_DIVISOR;
        rem_next = rem_reg;
        trial    = '0;
        qdigit   = '0;
        for (int j = 0; j < DIV_DIGIT; j++) begin
            trial = {rem_next, dvd_reg[DIV_W-1-j]};
            if (trial >= {1'b0, divisor}) begin
                rem_next = DIV_RW'(trial - {1'b0, divisor});
                qdigit[DIV_DIGIT-1-j] = 1'b1;
            end else begin
                rem_next = trial[DIV_RW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (div_req.start) begin
                dvd_reg  <= div_req.dividend;
                cone_reg <= div_req.cone;
                rem_reg  <= '0;
                quo_reg  <= '0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                dvd_reg <= {dvd_reg[DIV_W-DIV_DIGIT-1:0], {DIV_DIGIT{1'b0}}};
                rem_reg <= rem_next;
                quo_reg <= {quo_reg[DIV_W-DIV_DIGIT-1:0], qdigit};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign div_rsp.done     = done_reg;
    assign div_rsp.quotient = quo_reg;

endmodule

>>> hdl/coning_delta_angle_integrator_core.sv
// Top level: sequencer, per-sensor state and stream ports of the delta-angle integrator.
//
//  channel   | ports                     | moves
//  ----------+---------------------------+------------------------------------------
//  input     | s_tvalid/s_tready/s_tdata | one sample or publish transaction
//            | s_tuser                   |
//  result    | m_tvalid/m_tready/m_tdata | one result per input transaction
//            | m_tuser                   |
//  config    | cfg_wr_en/index/wdata     | register write, no read-back
//
// A gyro sample runs three trapezoid products and three divides by 15625, three
// divides by 6, then six cross products, all through one 40x20 multiplier (two passes
// per product) and one divider retiring eight quotient bits a cycle. Reset is
// synchronous and clears all sensor state at once. s_tready is high only when the
// sequencer is idle; a finished result waiting in the output register does not
// hold back the next transaction.
module coning_delta_angle_integrator_core #(
    parameter int NUM_SENSORS = cdi_pkg::NUM_SENSORS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [1:0] sensor_index, [25:2] gyro_x, [49:26] gyro_y, [73:50] gyro_z,
    // [105:74] sample_time_us, [137:106] now_us, [143:138] zero
    input  logic [cdi_pkg::IN_DATA_W-1:0]     s_tdata,
    // [0] kind
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [39:0] angle_x, [79:40] angle_y, [119:80] angle_z, [151:120] angle_time_us
    output logic [cdi_pkg::OUT_DATA_W-1:0]    m_tdata,
    // [0] sample_accepted, [1] angle_valid
    output logic [cdi_pkg::OUT_USER_W-1:0]    m_tuser,
    input  logic                              cfg_wr_en,
    input  logic [cdi_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cdi_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import cdi_pkg::*;

    localparam int SIDX_W = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_TRAP_MUL,
        S_TRAP_DIV,
        S_CONE_DIV,
        S_CROSS_MUL,
        S_UPDATE,
        S_OUT
    } state_t;

    state_t state_reg;
    logic [1:0] ax_reg;
    logic [2:0] pr_reg;
    logic [1:0] ph_reg;

    // configuration
    logic [PERIOD_W-1:0] nominal_reg;
    logic [GAP_W-1:0]    gap_reg;

    // per-sensor state
    logic signed [ANGLE_W-1:0] acc_arr   [NUM_SENSORS][3];
    logic signed [ANGLE_W-1:0] pd_arr    [NUM_SENSORS][3];
    logic signed [GYRO_W-1:0]  pg_arr    [NUM_SENSORS][3];
    logic [TIME_W-1:0]         atime_arr [NUM_SENSORS];
    logic [TIME_W-1:0]         last_arr  [NUM_SENSORS];

    // captured transaction
    logic                      kind_reg;
    logic [1:0]                idx_reg;
    logic signed [GYRO_W-1:0]  g_reg [3];
    logic [TIME_W-1:0]         ts_reg;
    logic [TIME_W-1:0]         now_reg;

    // working set
    logic [TIME_W-1:0]         dt_reg;
    logic [TIME_W-1:0]         last_new_reg;
    logic [TIME_W-1:0]         atime_reg;
    logic signed [ANGLE_W-1:0] acc_reg [3];
    logic signed [ANGLE_W-1:0] pd_reg  [3];
    logic [GYRO_W:0]           smag_reg [3];
    logic                      sneg_reg [3];
    logic signed [ANGLE_W-1:0] d_reg [3];
    logic signed [ANGLE_W-1:0] a_reg [3];
    logic signed [47:0]        c_reg [3];
    logic [MUL_PW-1:0]         pacc_reg;

    // result staging and output register
    logic                      res_acc_reg;
    logic                      res_valid_reg;
    logic signed [ANGLE_W-1:0] res_ang_reg [3];
    logic [TIME_W-1:0]         res_time_reg;
    logic                      m_tvalid_reg;
    logic                      out_acc_reg;
    logic                      out_valid_reg;
    logic signed [ANGLE_W-1:0] out_ang_reg [3];
    logic [TIME_W-1:0]         out_time_reg;

    logic [SIDX_W-1:0]         sidx;
    logic                      idx_ok;
    logic [TIME_W-1:0]         old_time;
    logic                      use_ts;
    logic [TIME_W-1:0]         dt_raw;
    logic                      reject;
    logic                      gap_hit;
    logic signed [GYRO_W:0]    s_sum [3];

    logic [1:0]                ia;
    logic [1:0]                id;
    logic [1:0]                ck;
    logic                      csub;
    logic [ANGLE_W-1:0]        b40;
    logic [FULL_W-1:0]         full;
    logic [47:0]               hm;
    logic                      cneg;
    logic signed [48:0]        cone_sum;
    logic signed [48:0]        upd_sum [3];
    logic [TIME_W:0]           time_sum;

    cdi_mul_req_t              mul_req;
    logic [MUL_PW-1:0]         mul_pp;
    cdi_div_req_t              div_req;
    cdi_div_rsp_t              div_rsp;

    cdi_mul u_mul (
        .aclk    (aclk),
        .mul_req (mul_req),
        .mul_pp  (mul_pp)
    );

    cdi_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .div_req (div_req),
        .div_rsp (div_rsp)
    );

    assign sidx   = SIDX_W'(idx_reg);
    assign idx_ok = (32'(idx_reg) < NUM_SENSORS);

    // sample timing decisions
    always_comb begin
        old_time = last_arr[sidx];
        use_ts   = (ts_reg != '0) && (old_time != '0);
        dt_raw   = use_ts ? (ts_reg - old_time) : TIME_W'(nominal_reg);
        reject   = !use_ts && ((nominal_reg == '0) || (nominal_reg > MAX_PERIOD_US));
        gap_hit  = (now_reg - old_time) > TIME_W'(gap_reg);
        for (int k = 0; k < 3; k++) begin
            s_sum[k] = {g_reg[k][GYRO_W-1], g_reg[k]}
                     + {pg_arr[sidx][k][GYRO_W-1], pg_arr[sidx][k]};
        end
    end

    // cross product schedule: c0 = a1*d2 - a2*d1, c1 = a2*d0 - a0*d2, c2 = a0*d1 - a1*d0
    always_comb begin
        case (pr_reg)
            3'd0:    begin ia = 2'd1; id = 2'd2; ck = 2'd0; csub = 1'b0; end
            3'd1:    begin ia = 2'd2; id = 2'd1; ck = 2'd0; csub = 1'b1; end
            3'd2:    begin ia = 2'd2; id = 2'd0; ck = 2'd1; csub = 1'b0; end
            3'd3:    begin ia = 2'd0; id = 2'd2; ck = 2'd1; csub = 1'b1; end
            3'd4:    begin ia = 2'd0; id = 2'd1; ck = 2'd2; csub = 1'b0; end
            3'd5:    begin ia = 2'd1; id = 2'd0; ck = 2'd2; csub = 1'b1; end
            default: begin ia = 2'd0; id = 2'd0; ck = 2'd0; csub = 1'b0; end
        endcase
    end

    // multiplier and divider operands
    always_comb begin
        case (state_reg)
            S_TRAP_MUL: begin
                mul_req.a = MUL_AW'(smag_reg[ax_reg]);
                b40       = ANGLE_W'(dt_reg);
            end
            S_CROSS_MUL: begin
                mul_req.a = abs40(a_reg[ia]);
                b40       = abs40(d_reg[id]);
            end
            default: begin
                mul_req.a = '0;
                b40       = '0;
            end
        endcase
        mul_req.b = (ph_reg == 2'd0) ? b40[MUL_BW-1:0] : b40[ANGLE_W-1:MUL_BW];
        full      = FULL_W'(pacc_reg) + {mul_pp, {MUL_BW{1'b0}}};
        hm        = 48'(full[FULL_W-1:33]);
        cneg      = a_reg[ia][ANGLE_W-1] ^ d_reg[id][ANGLE_W-1] ^ csub;

        div_req.start    = ((state_reg == S_TRAP_MUL) && (ph_reg == 2'd2))
                        || ((state_reg == S_CONE_DIV) && (ph_reg == 2'd0));
        div_req.cone     = (state_reg == S_CONE_DIV);
        div_req.dividend = (state_reg == S_CONE_DIV) ? DIV_W'(abs40(pd_reg[ax_reg]))
                                                     : DIV_W'({full[56:0], 9'd0});

        // acc + trunc(prev_delta / 6)
        cone_sum = {{9{acc_reg[ax_reg][ANGLE_W-1]}}, acc_reg[ax_reg]}
                 + (pd_reg[ax_reg][ANGLE_W-1] ? -{9'd0, div_rsp.quotient[ANGLE_W-1:0]}
                                              :  {9'd0, div_rsp.quotient[ANGLE_W-1:0]});

        for (int k = 0; k < 3; k++) begin
            upd_sum[k] = {{9{acc_reg[k][ANGLE_W-1]}}, acc_reg[k]}
                       + {{9{d_reg[k][ANGLE_W-1]}}, d_reg[k]}
                       + {c_reg[k][47], c_reg[k]};
        end
        time_sum = {1'b0, atime_reg} + {1'b0, dt_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nominal_reg <= '0;
            gap_reg     <= GAP_TIMEOUT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_NOMINAL_PERIOD: nominal_reg <= cfg_wdata[PERIOD_W-1:0];
                CFG_GAP_TIMEOUT:    gap_reg     <= cfg_wdata[GAP_W-1:0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            ax_reg       <= '0;
            pr_reg       <= '0;
            ph_reg       <= '0;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < NUM_SENSORS; i++) begin
                atime_arr[i] <= '0;
                last_arr[i]  <= '0;
                for (int k = 0; k < 3; k++) begin
                    acc_arr[i][k] <= '0;
                    pd_arr[i][k]  <= '0;
                    pg_arr[i][k]  <= '0;
                end
            end
        end else begin
            // in S_OUT the output register is reloaded below
            if (m_tvalid_reg && m_tready && (state_reg != S_OUT)) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        kind_reg <= s_tuser;
                        idx_reg  <= s_tdata[1:0];
                        g_reg[0] <= s_tdata[25:2];
                        g_reg[1] <= s_tdata[49:26];
                        g_reg[2] <= s_tdata[73:50];
                        ts_reg   <= s_tdata[105:74];
                        now_reg  <= s_tdata[137:106];
                        state_reg <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    res_acc_reg <= 1'b0;
                    if (idx_ok && (kind_reg == KIND_PUBLISH)) begin
                        res_valid_reg   <= 1'b1;
                        res_time_reg    <= atime_arr[sidx];
                        atime_arr[sidx] <= '0;
                        for (int k = 0; k < 3; k++) begin
                            res_ang_reg[k]     <= acc_arr[sidx][k];
                            acc_arr[sidx][k] <= '0;
                        end
                        state_reg <= S_OUT;
                    end else begin
                        res_valid_reg <= 1'b0;
                        res_time_reg  <= '0;
                        for (int k = 0; k < 3; k++) begin
                            res_ang_reg[k] <= '0;
                        end
                        if (idx_ok && !reject) begin
                            dt_reg       <= gap_hit ? '0 : dt_raw;
                            atime_reg    <= gap_hit ? '0 : atime_arr[sidx];
                            last_new_reg <= use_ts ? ts_reg : now_reg;
                            for (int k = 0; k < 3; k++) begin
                                acc_reg[k]  <= gap_hit ? '0 : acc_arr[sidx][k];
                                pd_reg[k]   <= pd_arr[sidx][k];
                                sneg_reg[k] <= s_sum[k][GYRO_W];
                                smag_reg[k] <= s_sum[k][GYRO_W] ? (GYRO_W + 1)'(-s_sum[k])
                                                                : (GYRO_W + 1)'(s_sum[k]);
                                c_reg[k]    <= '0;
                            end
                            ax_reg    <= '0;
                            ph_reg    <= '0;
                            state_reg <= S_TRAP_MUL;
                        end else begin
                            // no such sensor or rejected sample: all-zero result
                            state_reg <= S_OUT;
                        end
                    end
                end
                S_TRAP_MUL: begin
                    // low half, high half, then the sum goes to the divider
                    if (ph_reg == 2'd1) begin
                        pacc_reg <= mul_pp;
                    end
                    if (ph_reg == 2'd2) begin
                        ph_reg    <= '0;
                        state_reg <= S_TRAP_DIV;
                    end else begin
                        ph_reg <= ph_reg + 1'b1;
                    end
                end
                S_TRAP_DIV: begin
                    if (div_rsp.done) begin
                        d_reg[ax_reg] <= sat_mag(sneg_reg[ax_reg], div_rsp.quotient[MAG_W-1:0]);
                        ph_reg <= '0;
                        if (ax_reg == 2'd2) begin
                            ax_reg    <= '0;
                            state_reg <= S_CONE_DIV;
                        end else begin
                            ax_reg    <= ax_reg + 1'b1;
                            state_reg <= S_TRAP_MUL;
                        end
                    end
                end
                S_CONE_DIV: begin
                    if (ph_reg == 2'd0) begin
                        ph_reg <= 2'd1;
                    end else if (div_rsp.done) begin
                        a_reg[ax_reg] <= sat40(cone_sum);
                        ph_reg <= '0;
                        if (ax_reg == 2'd2) begin
                            ax_reg    <= '0;
                            pr_reg    <= '0;
                            state_reg <= S_CROSS_MUL;
                        end else begin
                            ax_reg <= ax_reg + 1'b1;
                        end
                    end
                end
                S_CROSS_MUL: begin
                    if (ph_reg == 2'd1) begin
                        pacc_reg <= mul_pp;
                    end
                    if (ph_reg == 2'd2) begin
                        // sign * floor(|a*d| / 2^33), added or taken off
                        c_reg[ck] <= cneg ? (c_reg[ck] - $signed(hm))
                                          : (c_reg[ck] + $signed(hm));
                        ph_reg <= '0;
                        if (pr_reg == 3'd5) begin
                            state_reg <= S_UPDATE;
                        end else begin
                            pr_reg <= pr_reg + 1'b1;
                        end
                    end else begin
                        ph_reg <= ph_reg + 1'b1;
                    end
                end
                S_UPDATE: begin
                    for (int k = 0; k < 3; k++) begin
                        acc_arr[sidx][k] <= sat40(upd_sum[k]);
                        pd_arr[sidx][k]  <= d_reg[k];
                        pg_arr[sidx][k]  <= g_reg[k];
                    end
                    atime_arr[sidx] <= time_sum[TIME_W] ? '1 : time_sum[TIME_W-1:0];
                    last_arr[sidx]  <= last_new_reg;
                    res_acc_reg     <= 1'b1;
                    state_reg       <= S_OUT;
                end
                S_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg  <= 1'b1;
                        out_acc_reg   <= res_acc_reg;
                        out_valid_reg <= res_valid_reg;
                        out_time_reg  <= res_time_reg;
                        for (int k = 0; k < 3; k++) begin
                            out_ang_reg[k] <= res_ang_reg[k];
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_time_reg, out_ang_reg[2], out_ang_reg[1], out_ang_reg[0]};
    assign m_tuser  = {out_valid_reg, out_acc_reg};

    a_div_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == S_TRAP_DIV || state_reg == S_CONE_DIV))
        else $error("divider finished outside a divide phase");

    a_one_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("result marked both accepted sample and publish");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input ready straight after a transaction");

    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT && (!m_tvalid || m_tready)) |=> (m_tvalid && s_tready))
        else $error("finished result not presented");

endmodule
